FILE: hdl/bfse_pkg.sv
// Shared types and constants for the boolean formula stack evaluator.
package bfse_pkg;

  typedef logic [2:0] opc_t;
  typedef logic [1:0] cmd_t;

  typedef struct packed {
    cmd_t cmd_top;
    cmd_t cmd_rest;
  } stack_ctl_t;

  localparam opc_t OPC_OPEN = 3'd0;
  localparam opc_t OPC_OR   = 3'd1;
  localparam opc_t OPC_AND  = 3'd2;
  localparam opc_t OPC_IMP  = 3'd3;
  localparam opc_t OPC_NOT  = 3'd4;

  localparam cmd_t CMD_HOLD = 2'd0;
  localparam cmd_t CMD_DOWN = 2'd1;
  localparam cmd_t CMD_UP1  = 2'd2;
  localparam cmd_t CMD_UP2  = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_OR    = 8'h56;
  localparam logic [7:0] CH_AND   = 8'h5E;
  localparam logic [7:0] CH_IMP   = 8'h3E;
  localparam logic [7:0] CH_NOT   = 8'h7E;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

FILE: hdl/bfse_cell.sv
// One stack cell: holds an entry and shifts it with its neighbors.
module bfse_cell import bfse_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] below1,
  input  logic [WIDTH-1:0] below2,
  output logic [WIDTH-1:0] entry
);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_HOLD: entry <= entry;
      CMD_DOWN: entry <= above;
      CMD_UP1:  entry <= below1;
      CMD_UP2:  entry <= below2;
      default:  entry <= entry;
    endcase
  end

endmodule

FILE: hdl/bfse_stack.sv
// Shift-register stack built as a row of cells, top at cell zero.
module bfse_stack import bfse_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  stack_ctl_t       ctl,
  input  logic [WIDTH-1:0] top_in,
  output logic [WIDTH-1:0] top0,
  output logic [WIDTH-1:0] top1
);

  logic [WIDTH-1:0] entries [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] above;
    logic [WIDTH-1:0] below1;
    logic [WIDTH-1:0] below2;
    cmd_t             cmd;

    if (i == 0) begin : g_top
      assign above = top_in;
      assign cmd   = ctl.cmd_top;
    end else begin : g_rest
      assign above = entries[i-1];
      assign cmd   = ctl.cmd_rest;
    end

    if (i + 1 < DEPTH) begin : g_b1
      assign below1 = entries[i+1];
    end else begin : g_b1_end
      assign below1 = '0;
    end

    if (i + 2 < DEPTH) begin : g_b2
      assign below2 = entries[i+2];
    end else begin : g_b2_end
      assign below2 = '0;
    end

    bfse_cell #(.WIDTH(WIDTH)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .above (above),
      .below1(below1),
      .below2(below2),
      .entry (entries[i])
    );
  end

  assign top0 = entries[0];
  assign top1 = entries[1];

endmodule

FILE: hdl/boolean_formula_stack_evaluator_core.sv
// Boolean formula stack evaluator: two cell-chain stacks and an output register.
// Result: registered, so it appears in the cycle after its end character is accepted.
// Throughput: one character per cycle unless a held result stalls the input.
// The stacks are rows of shifting cells, so only their top entries are ever read.
// Reset (synchronous, active high) clears both counts, the fault flag and the
// output valid; stack cell contents are not cleared.
module boolean_formula_stack_evaluator_core import bfse_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic [8:0] atom_values,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       value,
  output logic       fault
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] oper_count;
  logic [CW-1:0] oper_count_next;
  logic [CW-1:0] opnd_count;
  logic [CW-1:0] opnd_count_next;
  logic          fault_seen;
  logic          fault_seen_next;

  stack_ctl_t oper_ctl;
  stack_ctl_t opnd_ctl;
  opc_t       oper_in;
  logic       opnd_in;
  opc_t       oper_top;
  opc_t       oper_unused;
  logic       opnd_a;
  logic       opnd_b;

  logic       in_fire;
  logic       is_digit;
  logic       is_end;
  logic       emit;
  logic       a_val;
  logic       b_val;
  logic [3:0] atom_idx;
  logic [8:0] atom_shift;
  logic       oper_full;
  logic       opnd_full;

  assign in_ready   = !out_valid || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign is_digit   = (ch inside {[CH_ONE:CH_NINE]});
  assign is_end     = !(is_digit || ch == CH_OPEN || ch == CH_CLOSE || ch == CH_OR ||
                        ch == CH_AND || ch == CH_IMP || ch == CH_NOT);
  assign atom_idx   = 4'(ch - CH_ONE);
  assign atom_shift = atom_values >> atom_idx;
  assign oper_full  = (oper_count == CW'(STACK_DEPTH));
  assign opnd_full  = (opnd_count == CW'(STACK_DEPTH));
  assign a_val      = (opnd_count != '0) ? opnd_a : 1'b0;
  assign b_val      = (opnd_count >= CW'(2)) ? opnd_b : 1'b0;

  bfse_stack #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oper (
    .clk   (clk),
    .ctl   (oper_ctl),
    .top_in(oper_in),
    .top0  (oper_top),
    .top1  (oper_unused)
  );

  bfse_stack #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_opnd (
    .clk   (clk),
    .ctl   (opnd_ctl),
    .top_in(opnd_in),
    .top0  (opnd_a),
    .top1  (opnd_b)
  );

  always_comb begin
    oper_ctl        = '{cmd_top: CMD_HOLD, cmd_rest: CMD_HOLD};
    opnd_ctl        = '{cmd_top: CMD_HOLD, cmd_rest: CMD_HOLD};
    oper_in         = OPC_OPEN;
    opnd_in         = 1'b0;
    oper_count_next = oper_count;
    opnd_count_next = opnd_count;
    fault_seen_next = fault_seen;
    emit            = 1'b0;
    if (in_fire) begin
      if (is_end) begin
        emit            = 1'b1;
        oper_count_next = '0;
        opnd_count_next = '0;
        fault_seen_next = 1'b0;
      end else if (is_digit) begin
        if (opnd_full) begin
          fault_seen_next = 1'b1;
        end else begin
          opnd_ctl        = '{cmd_top: CMD_DOWN, cmd_rest: CMD_DOWN};
          opnd_in         = atom_shift[0];
          opnd_count_next = opnd_count + CW'(1);
        end
      end else if (ch == CH_CLOSE) begin
        if (oper_count == '0) begin
          fault_seen_next = 1'b1;
        end else if (oper_top == OPC_OR || oper_top == OPC_AND || oper_top == OPC_IMP) begin
          case (oper_top)
            OPC_OR:  opnd_in = a_val | b_val;
            OPC_AND: opnd_in = a_val & b_val;
            default: opnd_in = a_val | ~b_val;
          endcase
          opnd_ctl        = '{cmd_top: CMD_DOWN, cmd_rest: CMD_UP1};
          opnd_count_next = (opnd_count >= CW'(2)) ? opnd_count - CW'(1) : CW'(1);
          oper_ctl        = '{cmd_top: CMD_UP2, cmd_rest: CMD_UP2};
          oper_count_next = (oper_count >= CW'(2)) ? oper_count - CW'(2) : '0;
          if (opnd_count < CW'(2) || oper_count < CW'(2)) begin
            fault_seen_next = 1'b1;
          end
        end else if (oper_top == OPC_NOT) begin
          opnd_in         = ~a_val;
          opnd_ctl        = '{cmd_top: CMD_DOWN, cmd_rest: CMD_HOLD};
          opnd_count_next = (opnd_count == '0) ? CW'(1) : opnd_count;
          oper_ctl        = '{cmd_top: CMD_UP2, cmd_rest: CMD_UP2};
          oper_count_next = (oper_count >= CW'(2)) ? oper_count - CW'(2) : '0;
          if (opnd_count == '0 || oper_count < CW'(2)) begin
            fault_seen_next = 1'b1;
          end
        end else begin
          fault_seen_next = 1'b1;
        end
      end else begin
        if (oper_full) begin
          fault_seen_next = 1'b1;
        end else begin
          case (ch)
            CH_OR:   oper_in = OPC_OR;
            CH_AND:  oper_in = OPC_AND;
            CH_IMP:  oper_in = OPC_IMP;
            CH_NOT:  oper_in = OPC_NOT;
            default: oper_in = OPC_OPEN;
          endcase
          oper_ctl        = '{cmd_top: CMD_DOWN, cmd_rest: CMD_DOWN};
          oper_count_next = oper_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oper_count <= '0;
      opnd_count <= '0;
      fault_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      oper_count <= oper_count_next;
      opnd_count <= opnd_count_next;
      fault_seen <= fault_seen_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value <= a_val;
      fault <= fault_seen || (opnd_count == '0);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    oper_count <= CW'(STACK_DEPTH) && opnd_count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_end |=> out_valid && oper_count == '0 && opnd_count == '0 && !fault_seen)
    else $error("end item did not clear state");

  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_end && opnd_count == '0 |=> fault && !value)
    else $error("empty end pop not flagged");

  a_digit_push: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_digit && !opnd_full |=> opnd_count == $past(opnd_count) + CW'(1))
    else $error("operand push lost");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result held");

endmodule
